// File: sv/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam logic [1:0] KindUnit     = 2'd0;
	localparam logic [1:0] KindInvalid  = 2'd1;
	localparam logic [1:0] KindEndClean = 2'd2;
	localparam logic [1:0] KindEndOpen  = 2'd3;

	localparam int unsigned UnitW  = 21;
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam logic [UnitW-1:0] SurrBase = 21'h010000;
	localparam logic [UnitW-1:0] SurrHigh = 21'h00D800;
	localparam logic [UnitW-1:0] SurrLow  = 21'h00DC00;

	typedef struct packed {
		logic [1:0]       kind0;
		logic [UnitW-1:0] unit0;
		logic [1:0]       kind1;
		logic [UnitW-1:0] unit1;
		logic             two;
	} job_t;

endpackage

// File: sv/utf8_to_codepoint_decoder_top.sv
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+-------------------------------
// cfg     | cfg_wr_en            | cfg_wr_data (surrogate mode)
// in      | in_valid / in_stall  | in_byte, flush
// out     | out_valid / out_stall| kind, code_unit, last
//
// One byte is taken per cycle unless in_stall; any job it yields is queued at the transfer edge.
// A queued job passes from the job queue into the output register.
// A surrogate pair, or an invalid plus a result, leaves as two results; last marks the second.
// in_stall rises only while the job queue is full; bytes that yield nothing still need a free slot.
// arst_n clears decoder state, queue pointers, output valid and the surrogate mode register.

module utf8_to_codepoint_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        flush,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [20:0] code_unit,
	output logic        last
);

	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	utf8d_pkg::job_t push_job;
	utf8d_pkg::job_t head_job;

	utf8d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.flush       (flush),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	utf8d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	utf8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.code_unit (code_unit),
		.last      (last)
	);

endmodule

// File: sv/utf8d_front.sv
`timescale 1ns / 1ps

module utf8d_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 in_byte,
	input  logic                       flush,
	input  logic                       q_full,
	output logic                       push,
	output utf8d_pkg::job_t            push_job
);

	logic                        surr_q;
	logic [utf8d_pkg::UnitW-1:0] acc_q;
	logic [1:0]                  bl_q;
	logic [2:0]                  sl_q;
	logic                        skip_q;

	logic [utf8d_pkg::UnitW-1:0] acc_d;
	logic [1:0]                  bl_d;
	logic [2:0]                  sl_d;
	logic                        skip_d;

	logic                        accept;
	logic                        is_cont;
	logic                        is_high;

	logic                        l_emit;
	logic [1:0]                  l_kind;
	logic [utf8d_pkg::UnitW-1:0] l_unit;
	logic [utf8d_pkg::UnitW-1:0] l_acc;
	logic [1:0]                  l_bl;
	logic [2:0]                  l_sl;
	logic                        l_skip;

	logic [utf8d_pkg::UnitW-1:0] acc_sh;
	logic [utf8d_pkg::UnitW-1:0] cp_off;
	logic                        bad;
	logic                        emit;
	utf8d_pkg::job_t             job;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign is_high  = (in_byte[7:3] == 5'b11111);

	// lead byte decode
	always_comb begin
		l_emit = 1'b0;
		l_kind = utf8d_pkg::KindUnit;
		l_unit = '0;
		l_acc  = '0;
		l_bl   = 2'd0;
		l_sl   = 3'd0;
		l_skip = 1'b0;
		if (skip_q && (is_cont || is_high)) begin
			l_skip = 1'b1;
		end else if (!in_byte[7]) begin
			l_emit = 1'b1;
			l_unit = {13'd0, in_byte};
		end else if (in_byte[7:5] == 3'b110) begin
			l_acc = {16'd0, in_byte[4:0]};
			l_bl  = 2'd1;
			l_sl  = 3'd2;
		end else if (in_byte[7:4] == 4'b1110) begin
			l_acc = {17'd0, in_byte[3:0]};
			l_bl  = 2'd2;
			l_sl  = 3'd3;
		end else if (in_byte[7:3] == 5'b11110) begin
			l_acc = {18'd0, in_byte[2:0]};
			l_bl  = 2'd3;
			l_sl  = 3'd4;
		end else begin
			l_emit = 1'b1;
			l_kind = utf8d_pkg::KindInvalid;
			l_skip = 1'b1;
		end
	end

	assign acc_sh = {acc_q[14:0], in_byte[5:0]};
	assign cp_off = acc_sh - utf8d_pkg::SurrBase;
	assign bad    = ((sl_q == 3'd2) && (acc_sh[20:7] == '0)) ||
	                ((sl_q == 3'd3) && (acc_sh[20:11] == '0)) ||
	                ((sl_q == 3'd4) && (acc_sh[20:16] == '0));

	always_comb begin
		acc_d     = acc_q;
		bl_d      = bl_q;
		sl_d      = sl_q;
		skip_d    = skip_q;
		emit      = 1'b0;
		job.kind0 = utf8d_pkg::KindUnit;
		job.unit0 = '0;
		job.kind1 = utf8d_pkg::KindUnit;
		job.unit1 = '0;
		job.two   = 1'b0;
		if (flush) begin
			emit      = 1'b1;
			job.kind0 = (bl_q != 2'd0) ? utf8d_pkg::KindEndOpen : utf8d_pkg::KindEndClean;
			acc_d     = '0;
			bl_d      = 2'd0;
			sl_d      = 3'd0;
			skip_d    = 1'b0;
		end else if (bl_q != 2'd0) begin
			if (is_cont) begin
				bl_d = 2'(bl_q - 2'd1);
				if (bl_q == 2'd1) begin
					acc_d = '0;
					sl_d  = 3'd0;
					emit  = 1'b1;
					if (bad) begin
						job.kind0 = utf8d_pkg::KindInvalid;
					end else if (surr_q && (acc_sh[20:16] != '0)) begin
						job.unit0 = utf8d_pkg::SurrHigh + utf8d_pkg::UnitW'(cp_off[20:10]);
						job.unit1 = utf8d_pkg::SurrLow + utf8d_pkg::UnitW'(cp_off[9:0]);
						job.two   = 1'b1;
					end else begin
						job.unit0 = acc_sh;
					end
				end else begin
					acc_d = acc_sh;
				end
			end else begin
				emit      = 1'b1;
				job.kind0 = utf8d_pkg::KindInvalid;
				job.kind1 = l_kind;
				job.unit1 = l_unit;
				job.two   = l_emit;
				acc_d     = l_acc;
				bl_d      = l_bl;
				sl_d      = l_sl;
				skip_d    = l_skip;
			end
		end else begin
			emit      = l_emit;
			job.kind0 = l_kind;
			job.unit0 = l_unit;
			acc_d     = l_acc;
			bl_d      = l_bl;
			sl_d      = l_sl;
			skip_d    = l_skip;
		end
	end

	assign push     = accept && emit;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surr_q <= 1'b0;
			acc_q  <= '0;
			bl_q   <= 2'd0;
			sl_q   <= 3'd0;
			skip_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				surr_q <= cfg_wr_data;
			end
			if (accept) begin
				acc_q  <= acc_d;
				bl_q   <= bl_d;
				sl_q   <= sl_d;
				skip_q <= skip_d;
			end
		end
	end

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && flush) |=> (bl_q == 2'd0 && !skip_q && sl_q == 3'd0))
		else $error("flush left decoder state open");

	a_skip_idle: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (bl_q == 2'd0))
		else $error("skipping while a sequence is open");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bl_q != 2'd0) |-> ({1'b0, bl_q} < sl_q))
		else $error("bytes left not below sequence length");

endmodule

// File: sv/utf8d_queue.sv
`timescale 1ns / 1ps

module utf8d_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utf8d_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output utf8d_pkg::job_t head_job
);

	utf8d_pkg::job_t                mem_q [utf8d_pkg::QDepth];
	logic [utf8d_pkg::QPtrW-1:0]    wr_ptr_q;
	logic [utf8d_pkg::QPtrW-1:0]    rd_ptr_q;
	logic [utf8d_pkg::QCntW-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full     = (count_q == utf8d_pkg::QCntW'(utf8d_pkg::QDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	function automatic logic [utf8d_pkg::QPtrW-1:0] ptr_inc(
		input logic [utf8d_pkg::QPtrW-1:0] p
	);
		if (p == utf8d_pkg::QPtrW'(utf8d_pkg::QDepth - 1)) begin
			return '0;
		end
		return utf8d_pkg::QPtrW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= utf8d_pkg::QCntW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= utf8d_pkg::QCntW'(count_q - 1'b1);
			end
		end
	end

endmodule

// File: sv/utf8d_back.sv
`timescale 1ns / 1ps

module utf8d_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  utf8d_pkg::job_t             head_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [utf8d_pkg::UnitW-1:0] code_unit,
	output logic                        last
);

	logic                        valid_q;
	logic                        phase_q;
	logic [1:0]                  kind_q;
	logic [utf8d_pkg::UnitW-1:0] unit_q;
	logic                        last_q;
	logic                        load;

	assign load      = !valid_q || !out_stall;
	assign pop       = load && !empty && (phase_q || !head_job.two);
	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign code_unit = unit_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (phase_q) begin
				kind_q <= head_job.kind1;
				unit_q <= head_job.unit1;
				last_q <= 1'b1;
			end else begin
				kind_q <= head_job.kind0;
				unit_q <= head_job.unit0;
				last_q <= !head_job.two;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				phase_q <= !phase_q && head_job.two;
			end
		end
	end

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last_q && !out_stall) |=> (valid_q && last_q))
		else $error("second result of a pair did not follow");

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!empty && head_job.two && valid_q && !last_q))
		else $error("second half pending without a paired job at the head");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int QuietLimit  = 2000;
	localparam int PhaseItems  = 250;
	localparam int PhaseCount  = 6;
	localparam int SettleSlack = 8;

	typedef struct {
		logic [1:0]  kind;
		logic [20:0] unit;
		logic        last;
	} unit_t;

	typedef struct {
		logic [7:0]  b;
		logic        f;
		logic        m;
		logic        typed;
		logic [1:0]  kind;
		logic [20:0] unit;
	} script_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid    = 1'b0;
	logic [7:0]  in_byte     = 8'h00;
	logic        flush       = 1'b0;
	logic        out_stall   = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [20:0] code_unit;
	logic        last;

	utf8_to_codepoint_decoder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.flush       (flush),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.code_unit   (code_unit),
		.last        (last)
	);

	always #5 clk = ~clk;

	// decoder state mirror
	logic        surr_mode = 1'b0;
	logic [20:0] acc_bits  = '0;
	logic [1:0]  cont_left = '0;
	logic [2:0]  seq_bytes = '0;
	logic        skip_bad  = 1'b0;

	unit_t byte_results [$];
	unit_t awaited_units [$];
	int    errors     = 0;
	int    items_sent = 0;
	int    quiet      = 0;
	int    hold_cnt   = 0;
	bit    in_steady  = 1'b0;
	bit    out_steady = 1'b0;

	function automatic void emit(input logic [1:0] k, input logic [20:0] u);
		unit_t r;
		r.kind = k;
		r.unit = u;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void emit_point(input logic [20:0] cp);
		logic [20:0] v;
		if (surr_mode && cp > 21'h00FFFF) begin
			v = cp - utf8d_pkg::SurrBase;
			emit(utf8d_pkg::KindUnit, (v >> 10) + utf8d_pkg::SurrHigh);
			emit(utf8d_pkg::KindUnit, (v & 21'h0003FF) + utf8d_pkg::SurrLow);
		end else begin
			emit(utf8d_pkg::KindUnit, cp);
		end
	endfunction

	function automatic void take_lead(input logic [7:0] b);
		if (skip_bad) begin
			if (b[7:6] == 2'b10 || b >= 8'hF8)
				return;
			skip_bad = 1'b0;
		end
		if (!b[7]) begin
			emit(utf8d_pkg::KindUnit, {13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			acc_bits  = {16'd0, b[4:0]};
			cont_left = 2'd1;
			seq_bytes = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			acc_bits  = {17'd0, b[3:0]};
			cont_left = 2'd2;
			seq_bytes = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			acc_bits  = {18'd0, b[2:0]};
			cont_left = 2'd3;
			seq_bytes = 3'd4;
		end else begin
			skip_bad = 1'b1;
			emit(utf8d_pkg::KindInvalid, '0);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic f);
		logic [20:0] cp;
		logic        bad;
		byte_results.delete();
		if (f) begin
			emit(cont_left != 2'd0 ? utf8d_pkg::KindEndOpen : utf8d_pkg::KindEndClean, '0);
			acc_bits  = '0;
			cont_left = '0;
			seq_bytes = '0;
			skip_bad  = 1'b0;
		end else if (cont_left != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				acc_bits  = {acc_bits[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					cp  = acc_bits;
					bad = (seq_bytes == 3'd2 && cp < 21'h000080) ||
					      (seq_bytes == 3'd3 && cp < 21'h000800) ||
					      (seq_bytes == 3'd4 && cp <= 21'h00FFFF);
					acc_bits  = '0;
					seq_bytes = '0;
					if (bad)
						emit(utf8d_pkg::KindInvalid, '0);
					else
						emit_point(cp);
				end
			end else begin
				acc_bits  = '0;
				cont_left = '0;
				seq_bytes = '0;
				emit(utf8d_pkg::KindInvalid, '0);
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (in_steady || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// hold each stall decision for a random stretch
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_stall <= !out_steady && ($urandom_range(0, 2) == 0);
			hold_cnt  <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
			                                          : $urandom_range(8, 30);
		end
	end

	always @(posedge clk) begin
		unit_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, got kind %0d unit %h last %0d",
					$time, kind, code_unit, last);
			end else begin
				want = awaited_units.pop_front();
				if (kind !== want.kind || code_unit !== want.unit || last !== want.last) begin
					errors++;
					$display({"%0t: mismatch, expected kind %0d unit %h last %0d,",
						" got kind %0d unit %h last %0d"}, $time, want.kind,
						want.unit, want.last, kind, code_unit, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else if (quiet >= QuietLimit) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet++;
		end
	end

	task automatic send(input logic [7:0] b, input logic f, input logic typed = 1'b0,
		input logic [1:0] t_kind = utf8d_pkg::KindUnit, input logic [20:0] t_unit = '0);
		int    gap;
		unit_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		flush    <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		decode_byte(b, f);
		if (typed) begin
			r.kind = t_kind;
			r.unit = t_unit;
			r.last = 1'b1;
			awaited_units.push_back(r);
		end else begin
			foreach (byte_results[i])
				awaited_units.push_back(byte_results[i]);
		end
	endtask

	task automatic set_mode(input logic m);
		in_valid <= 1'b0;
		while (awaited_units.size() != 0)
			@(posedge clk);
		repeat (SettleSlack) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		surr_mode = m;
	endtask

	task automatic send_seq();
		logic [20:0] cp;
		logic [20:0] lo;
		logic [20:0] hi;
		logic [7:0]  seq [$];
		int          cls;
		int          len;
		int          keep;
		cls = $urandom_range(0, 99);
		if (cls < 4) begin
			send(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		if (cls < 14) begin
			send(8'($urandom_range(0, 255)), 1'b0);
			return;
		end
		len = $urandom_range(1, 4);
		case (len)
			1: begin lo = 21'h0;      hi = 21'h7F;     end
			2: begin lo = 21'h80;     hi = 21'h7FF;    end
			3: begin lo = 21'h800;    hi = 21'hFFFF;   end
			default: begin
				lo = 21'h10000;
				hi = ($urandom_range(0, 3) == 0) ? 21'h1FFFFF : 21'h10FFFF;
			end
		endcase
		cp = 21'($urandom_range(lo, hi));
		if ($urandom_range(0, 7) == 0)
			cp = $urandom_range(0, 1) ? lo : hi;
		if (cls < 22 && len > 1)
			cp = 21'($urandom_range(0, lo - 1));
		seq.delete();
		case (len)
			1: seq.push_back(cp[7:0]);
			2: begin
				seq.push_back({3'b110, cp[10:6]});
				seq.push_back({2'b10, cp[5:0]});
			end
			3: begin
				seq.push_back({4'b1110, cp[15:12]});
				seq.push_back({2'b10, cp[11:6]});
				seq.push_back({2'b10, cp[5:0]});
			end
			default: begin
				seq.push_back({5'b11110, cp[20:18]});
				seq.push_back({2'b10, cp[17:12]});
				seq.push_back({2'b10, cp[11:6]});
				seq.push_back({2'b10, cp[5:0]});
			end
		endcase
		if (cls >= 22 && cls < 30 && len > 1) begin
			keep = $urandom_range(1, len - 1);
			while (seq.size() > keep)
				void'(seq.pop_back());
		end
		foreach (seq[i])
			send(seq[i], 1'b0);
	endtask

	script_row_t script [25];

	initial begin
		int target;
		script = '{
			'{8'h00, 1'b1, 1'b0, 1'b1, utf8d_pkg::KindEndClean, 21'h0},
			'{8'h00, 1'b0, 1'b0, 1'b1, utf8d_pkg::KindUnit,     21'h0},
			'{8'h7F, 1'b0, 1'b0, 1'b1, utf8d_pkg::KindUnit,     21'h7F},
			'{8'h80, 1'b0, 1'b0, 1'b1, utf8d_pkg::KindInvalid,  21'h0},
			'{8'hFF, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hBF, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hC2, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hA9, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hC1, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hBF, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hE0, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h80, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h80, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hE2, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h41, 1'b0, 1'b0, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hF0, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h9F, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h98, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'h80, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hF7, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hBF, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hBF, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hBF, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hF4, 1'b0, 1'b1, 1'b0, utf8d_pkg::KindUnit,     21'h0},
			'{8'hFF, 1'b1, 1'b1, 1'b1, utf8d_pkg::KindEndOpen,  21'h0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_mode(1'b0);
		foreach (script[i]) begin
			if (script[i].m !== surr_mode)
				set_mode(script[i].m);
			send(script[i].b, script[i].f, script[i].typed, script[i].kind, script[i].unit);
		end
		for (int phase = 0; phase < PhaseCount; phase++) begin
			set_mode(phase[0]);
			in_steady  = (phase == 2) || ($urandom_range(0, 4) == 0);
			out_steady = (phase == 2) || ($urandom_range(0, 4) == 0);
			target = items_sent + PhaseItems;
			while (items_sent < target)
				send_seq();
		end
		in_valid <= 1'b0;
		while (awaited_units.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && awaited_units.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
